FILE: sv/c8x_pkg.sv
// ----------------------------------------------------------------------------
// c8x_pkg: shared types and constants for the CHIP-8 executor
// Geometry, opcode groups, micro-op codes and small helper functions.
// ----------------------------------------------------------------------------
package c8x_pkg;

  localparam int ADDR_W      = 12;
  localparam int MEM_SIZE    = 4096;
  localparam int SCREEN_W    = 64;
  localparam int SCREEN_H    = 32;
  localparam int COL_W       = $clog2(SCREEN_W);
  localparam int ROW_W       = $clog2(SCREEN_H);
  localparam int PIX_W       = 11;
  localparam int STACK_DEPTH = 16;
  localparam int SP_W        = $clog2(STACK_DEPTH);
  localparam logic [15:0]       FONT_BASE = 16'd80;
  localparam logic [ADDR_W-1:0] START_PC  = 12'h200;
  localparam int CNT_W       = 4;

  // item kinds
  localparam logic [1:0] KIND_EXEC  = 2'd0;
  localparam logic [1:0] KIND_MEMWR = 2'd1;
  localparam logic [1:0] KIND_MEMRD = 2'd2;
  localparam logic [1:0] KIND_PIXRD = 2'd3;

  // opcode groups (top nibble)
  localparam logic [3:0] OPG_SYS   = 4'h0;
  localparam logic [3:0] OPG_JP    = 4'h1;
  localparam logic [3:0] OPG_CALL  = 4'h2;
  localparam logic [3:0] OPG_SEI   = 4'h3;
  localparam logic [3:0] OPG_SNEI  = 4'h4;
  localparam logic [3:0] OPG_SER   = 4'h5;
  localparam logic [3:0] OPG_LDI   = 4'h6;
  localparam logic [3:0] OPG_ADDI  = 4'h7;
  localparam logic [3:0] OPG_ALU   = 4'h8;
  localparam logic [3:0] OPG_SNER  = 4'h9;
  localparam logic [3:0] OPG_LDIX  = 4'hA;
  localparam logic [3:0] OPG_JPV0  = 4'hB;
  localparam logic [3:0] OPG_RND   = 4'hC;
  localparam logic [3:0] OPG_DRW   = 4'hD;
  localparam logic [3:0] OPG_KEY   = 4'hE;
  localparam logic [3:0] OPG_MISC  = 4'hF;

  localparam logic [15:0] OP_CLS = 16'h00E0;
  localparam logic [15:0] OP_RET = 16'h00EE;

  // 8XYn sub-ops
  localparam logic [3:0] ALU_MOV  = 4'h0;
  localparam logic [3:0] ALU_OR   = 4'h1;
  localparam logic [3:0] ALU_AND  = 4'h2;
  localparam logic [3:0] ALU_XOR  = 4'h3;
  localparam logic [3:0] ALU_ADD  = 4'h4;
  localparam logic [3:0] ALU_SUB  = 4'h5;
  localparam logic [3:0] ALU_SHR  = 4'h6;
  localparam logic [3:0] ALU_SUBN = 4'h7;
  localparam logic [3:0] ALU_SHL  = 4'hE;

  // EXnn / FXnn low bytes
  localparam logic [7:0] KEY_SKP  = 8'h9E;
  localparam logic [7:0] KEY_SKNP = 8'hA1;
  localparam logic [7:0] FN_DTRD  = 8'h07;
  localparam logic [7:0] FN_KWAIT = 8'h0A;
  localparam logic [7:0] FN_DTWR  = 8'h15;
  localparam logic [7:0] FN_STWR  = 8'h18;
  localparam logic [7:0] FN_ADDI  = 8'h1E;
  localparam logic [7:0] FN_FONT  = 8'h29;
  localparam logic [7:0] FN_BCD   = 8'h33;
  localparam logic [7:0] FN_STORE = 8'h55;
  localparam logic [7:0] FN_LOAD  = 8'h65;

  localparam logic [3:0] REG_VF = 4'hF;

  typedef logic [4:0] uop_t;
  localparam uop_t UOP_NONE     = 5'd0;
  localparam uop_t UOP_LATCH    = 5'd1;
  localparam uop_t UOP_MEMWR    = 5'd2;
  localparam uop_t UOP_MEMRD    = 5'd3;
  localparam uop_t UOP_RDATA    = 5'd4;
  localparam uop_t UOP_FBRD_PIX = 5'd5;
  localparam uop_t UOP_PIXEL    = 5'd6;
  localparam uop_t UOP_LDVX     = 5'd7;
  localparam uop_t UOP_LDVY     = 5'd8;
  localparam uop_t UOP_SIMPLE   = 5'd9;
  localparam uop_t UOP_ALU_FLAG = 5'd10;
  localparam uop_t UOP_ALU_RES  = 5'd11;
  localparam uop_t UOP_DR_INIT  = 5'd12;
  localparam uop_t UOP_DR_MEM   = 5'd13;
  localparam uop_t UOP_DR_FBRD  = 5'd14;
  localparam uop_t UOP_DR_WR    = 5'd15;
  localparam uop_t UOP_BCD      = 5'd16;
  localparam uop_t UOP_ST       = 5'd17;
  localparam uop_t UOP_LD_RD    = 5'd18;
  localparam uop_t UOP_LD_WR    = 5'd19;

  typedef struct packed {
    uop_t             uop;
    logic [CNT_W-1:0] cnt;
  } cmd_t;

  typedef struct packed {
    logic [1:0] kind;
    logic [3:0] op_hi;
    logic [3:0] x;
    logic [3:0] n;
    logic [7:0] nn;
    logic       row_ok;
  } sts_t;

  function automatic logic [7:0] bit_rev8(input logic [7:0] v);
    logic [7:0] r;
    for (int k = 0; k < 8; k++) r[k] = v[7-k];
    return r;
  endfunction

  // sel 0: hundreds, 1: tens, 2: ones; reciprocal multiply, no divider
  function automatic logic [7:0] bcd_digit(input logic [7:0] v, input logic [1:0] sel);
    logic [13:0] p1;
    logic [1:0]  h;
    logic [6:0]  t;
    logic [14:0] p2;
    logic [3:0]  tn;
    logic [3:0]  on;
    logic [7:0]  r;
    p1 = 14'(v) * 14'd41;
    h  = p1[13:12];
    t  = 7'(v - 8'(h) * 8'd100);
    p2 = 15'(t) * 15'd205;
    tn = p2[14:11];
    on = 4'(t - 7'(tn) * 7'd10);
    case (sel)
      2'd0:    r = 8'(h);
      2'd1:    r = 8'(tn);
      default: r = 8'(on);
    endcase
    return r;
  endfunction

  function automatic logic [3:0] lowest_key(input logic [15:0] keys);
    logic [3:0] k;
    k = '0;
    for (int i = 15; i >= 0; i--) begin
      if (keys[i]) k = 4'(i);
    end
    return k;
  endfunction

endpackage

FILE: sv/c8x_dpath.sv
// ----------------------------------------------------------------------------
// c8x_dpath: executor datapath
// Register file, pc/index/stack/timers, 4 KiB memory, row-organized frame
// buffer with per-row valid bits, ALU and sprite XOR unit.
// ----------------------------------------------------------------------------
module c8x_dpath import c8x_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  cmd_t              cmd_i,
  output sts_t              sts_o,
  input  logic [1:0]        kind_i,
  input  logic [15:0]       opcode_i,
  input  logic [15:0]       key_states_i,
  input  logic [7:0]        random_byte_i,
  input  logic [ADDR_W-1:0] mem_address_i,
  input  logic [7:0]        mem_write_data_i,
  input  logic [PIX_W-1:0]  pixel_index_i,
  output logic [ADDR_W-1:0] program_counter_o,
  output logic [15:0]       index_value_o,
  output logic [7:0]        flag_value_o,
  output logic [7:0]        read_data_o,
  output logic              pixel_on_o,
  output logic              key_wait_o,
  output logic [7:0]        sound_level_o,
  output logic [7:0]        delay_level_o
);

  // latched item
  logic [1:0]        kind_q;
  logic [15:0]       op_q, keys_q;
  logic [7:0]        rnd_q, wdata_q;
  logic [ADDR_W-1:0] maddr_q;
  logic [PIX_W-1:0]  pix_q;

  logic [7:0] vx_q, vx_d, vy_q, vy_d, flag_q, flag_d;

  logic [7:0]        rf_q [16];
  logic [ADDR_W-1:0] pc_q, pc_d;
  logic [15:0]       i_q, i_d;
  logic [SP_W-1:0]   sp_q, sp_d, sp_dec;
  logic [7:0]        delay_q, delay_d, sound_q, sound_d, rdata_q, rdata_d;
  logic              pon_q, pon_d, kw_q, kw_d;

  logic [ADDR_W-1:0] stk_q [STACK_DEPTH];
  logic              stk_we;

  logic [7:0]        mem_q [1];
  logic [7:0]        mem [MEM_SIZE];
  logic              mem_we, mem_re;
  logic [ADDR_W-1:0] mem_a;
  logic [7:0]        mem_wd;

  logic [SCREEN_W-1:0] fb_mem [SCREEN_H];
  logic [SCREEN_W-1:0] fb_q, fb_row, fb_wd, spr_mask;
  logic [SCREEN_H-1:0] fb_vld_q;
  logic                fb_vq, fb_re, fb_we, fb_clr;
  logic [ROW_W-1:0]    fb_ra, fb_wa;

  logic       rf_we;
  logic [3:0] rf_wa, rf_ra;
  logic [7:0] rf_wd, rf_rd;

  logic [3:0]        x, y, n;
  logic [7:0]        nn;
  logic [ADDR_W-1:0] nnn, i_off;
  logic [ROW_W:0]    ysum;
  logic              skip, has_flag, flag_c, collide;
  logic [7:0]        xe, ye, tsh, alu_res;
  logic [15:0]       isum;

  assign x   = op_q[11:8];
  assign y   = op_q[7:4];
  assign n   = op_q[3:0];
  assign nn  = op_q[7:0];
  assign nnn = op_q[ADDR_W-1:0];

  assign i_off  = i_q[ADDR_W-1:0] + ADDR_W'(cmd_i.cnt);
  assign ysum   = (ROW_W+1)'(vy_q[ROW_W-1:0]) + (ROW_W+1)'(cmd_i.cnt);
  assign sp_dec = (sp_q == '0) ? SP_W'(STACK_DEPTH - 1) : sp_q - 1'b1;
  assign fb_row = fb_vq ? fb_q : '0;
  assign spr_mask = SCREEN_W'(bit_rev8(mem_q[0])) << vx_q[COL_W-1:0];
  assign collide  = |(fb_row & spr_mask);
  assign isum     = i_q + 16'(vx_q);

  always_comb begin
    case (cmd_i.uop)
      UOP_LDVY: rf_ra = y;
      UOP_ST:   rf_ra = cmd_i.cnt;
      default:  rf_ra = x;
    endcase
  end
  assign rf_rd = rf_q[rf_ra];

  // ALU: VF is written first; ADD/SUB/SUBN operands naming VF see the new flag, a shift with X = VF shifts it
  always_comb begin
    has_flag = (n == ALU_ADD) || (n == ALU_SUB) || (n == ALU_SHR) ||
               (n == ALU_SUBN) || (n == ALU_SHL);
    case (n)
      ALU_ADD:  flag_c = (9'(vx_q) + 9'(vy_q)) > 9'h0FF;
      ALU_SUB:  flag_c = vx_q > vy_q;
      ALU_SHR:  flag_c = vy_q[0];
      ALU_SUBN: flag_c = vx_q < vy_q;
      default:  flag_c = vy_q[7];
    endcase
    xe  = (has_flag && x == REG_VF) ? flag_q : vx_q;
    ye  = (has_flag && y == REG_VF) ? flag_q : vy_q;
    tsh = (x == REG_VF) ? flag_q : vy_q;
    case (n)
      ALU_MOV:  alu_res = vy_q;
      ALU_OR:   alu_res = vx_q | vy_q;
      ALU_AND:  alu_res = vx_q & vy_q;
      ALU_XOR:  alu_res = vx_q ^ vy_q;
      ALU_ADD:  alu_res = xe + ye;
      ALU_SUB:  alu_res = xe - ye;
      ALU_SHR:  alu_res = tsh >> 1;
      ALU_SUBN: alu_res = ye - xe;
      default:  alu_res = tsh << 1;
    endcase
  end

  always_comb begin
    pc_d = pc_q; i_d = i_q; sp_d = sp_q;
    delay_d = delay_q; sound_d = sound_q;
    rdata_d = rdata_q; pon_d = pon_q; kw_d = kw_q;
    vx_d = vx_q; vy_d = vy_q; flag_d = flag_q;
    rf_we = 1'b0; rf_wa = x; rf_wd = '0;
    mem_we = 1'b0; mem_re = 1'b0; mem_a = i_off; mem_wd = '0;
    fb_re = 1'b0; fb_we = 1'b0; fb_clr = 1'b0;
    fb_ra = ysum[ROW_W-1:0]; fb_wa = ysum[ROW_W-1:0]; fb_wd = fb_row ^ spr_mask;
    stk_we = 1'b0; skip = 1'b0;
    case (cmd_i.uop)
      UOP_LATCH: begin
        rdata_d = '0; pon_d = 1'b0; kw_d = 1'b0;
      end
      UOP_MEMWR: begin
        mem_we = 1'b1; mem_a = maddr_q; mem_wd = wdata_q;
      end
      UOP_MEMRD: begin
        mem_re = 1'b1; mem_a = maddr_q;
      end
      UOP_RDATA: rdata_d = mem_q[0];
      UOP_FBRD_PIX: begin
        fb_re = 1'b1; fb_ra = pix_q[COL_W +: ROW_W];
      end
      UOP_PIXEL: pon_d = fb_row[pix_q[COL_W-1:0]];
      UOP_LDVX:  vx_d = rf_rd;
      UOP_LDVY:  vy_d = rf_rd;
      UOP_SIMPLE: begin
        case (op_q[15:12])
          OPG_SYS: begin
            if (op_q == OP_CLS) begin
              fb_clr = 1'b1;
            end else if (op_q == OP_RET) begin
              sp_d = sp_dec;
              pc_d = stk_q[sp_dec];
            end
          end
          OPG_JP: pc_d = nnn;
          OPG_CALL: begin
            stk_we = 1'b1;
            sp_d   = (sp_q == SP_W'(STACK_DEPTH - 1)) ? '0 : sp_q + 1'b1;
            pc_d   = nnn;
          end
          OPG_SEI:  skip = vx_q == nn;
          OPG_SNEI: skip = vx_q != nn;
          OPG_SER:  skip = (n == 4'h0) && (vx_q == vy_q);
          OPG_SNER: skip = (n == 4'h0) && (vx_q != vy_q);
          OPG_LDI: begin
            rf_we = 1'b1; rf_wd = nn;
          end
          OPG_ADDI: begin
            rf_we = 1'b1; rf_wd = vx_q + nn;
          end
          OPG_LDIX: i_d = 16'(nnn);
          OPG_JPV0: pc_d = nnn + ADDR_W'(rf_q[0]);
          OPG_RND: begin
            rf_we = 1'b1; rf_wd = rnd_q & nn;
          end
          OPG_KEY: begin
            if (nn == KEY_SKP) begin
              skip = (vx_q[7:4] == 4'h0) && keys_q[vx_q[3:0]];
            end else if (nn == KEY_SKNP) begin
              skip = !((vx_q[7:4] == 4'h0) && keys_q[vx_q[3:0]]);
            end
          end
          OPG_MISC: begin
            case (nn)
              FN_DTRD: begin
                rf_we = 1'b1; rf_wd = delay_q;
              end
              FN_DTWR: delay_d = vx_q;
              FN_STWR: sound_d = vx_q;
              FN_ADDI: begin
                i_d = isum;
                if (isum > 16'h0FFF) begin
                  rf_we = 1'b1; rf_wa = REG_VF; rf_wd = 8'd1;
                end
              end
              FN_KWAIT: begin
                if (keys_q != '0) begin
                  rf_we = 1'b1; rf_wd = 8'(lowest_key(keys_q));
                end else begin
                  pc_d = pc_q - ADDR_W'(2);
                  kw_d = 1'b1;
                end
              end
              FN_FONT: i_d = FONT_BASE + 16'({vx_q, 2'b00}) + 16'(vx_q);
              default: ;
            endcase
          end
          default: ;
        endcase
        if (skip) pc_d = pc_q + ADDR_W'(2);
      end
      UOP_ALU_FLAG: begin
        rf_we = 1'b1; rf_wa = REG_VF; rf_wd = 8'(flag_c); flag_d = 8'(flag_c);
      end
      UOP_ALU_RES: begin
        rf_we = 1'b1; rf_wd = alu_res;
      end
      UOP_DR_INIT: begin
        rf_we = 1'b1; rf_wa = REG_VF; rf_wd = '0;
      end
      UOP_DR_MEM:  mem_re = 1'b1;
      UOP_DR_FBRD: fb_re = 1'b1;
      UOP_DR_WR: begin
        fb_we = 1'b1;
        if (collide) begin
          rf_we = 1'b1; rf_wa = REG_VF; rf_wd = 8'd1;
        end
      end
      UOP_BCD: begin
        mem_we = 1'b1; mem_wd = bcd_digit(vx_q, cmd_i.cnt[1:0]);
      end
      UOP_ST: begin
        mem_we = 1'b1; mem_wd = rf_rd;
      end
      UOP_LD_RD: mem_re = 1'b1;
      UOP_LD_WR: begin
        rf_we = 1'b1; rf_wa = cmd_i.cnt; rf_wd = mem_q[0];
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.uop == UOP_LATCH) begin
      kind_q  <= kind_i;
      op_q    <= opcode_i;
      keys_q  <= key_states_i;
      rnd_q   <= random_byte_i;
      maddr_q <= mem_address_i;
      wdata_q <= mem_write_data_i;
      pix_q   <= pixel_index_i;
    end
    vx_q   <= vx_d;
    vy_q   <= vy_d;
    flag_q <= flag_d;
    if (stk_we) stk_q[sp_q] <= pc_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < 16; k++) rf_q[k] <= '0;
      pc_q <= START_PC; i_q <= '0; sp_q <= '0;
      delay_q <= '0; sound_q <= '0;
      rdata_q <= '0; pon_q <= 1'b0; kw_q <= 1'b0;
    end else begin
      if (rf_we) rf_q[rf_wa] <= rf_wd;
      pc_q <= pc_d; i_q <= i_d; sp_q <= sp_d;
      delay_q <= delay_d; sound_q <= sound_d;
      rdata_q <= rdata_d; pon_q <= pon_d; kw_q <= kw_d;
    end
  end

  // main memory, single port, registered read
  always_ff @(posedge clk_i) begin
    if (mem_we) mem[mem_a] <= mem_wd;
    if (mem_re) mem_q[0] <= mem[mem_a];
  end

  // frame buffer rows; a row never written since reset or clear reads as zero
  always_ff @(posedge clk_i) begin
    if (fb_we) fb_mem[fb_wa] <= fb_wd;
    if (fb_re) begin
      fb_q  <= fb_mem[fb_ra];
      fb_vq <= fb_vld_q[fb_ra];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fb_vld_q <= '0;
    end else if (fb_clr) begin
      fb_vld_q <= '0;
    end else if (fb_we) begin
      fb_vld_q[fb_wa] <= 1'b1;
    end
  end

  assign sts_o.kind   = kind_q;
  assign sts_o.op_hi  = op_q[15:12];
  assign sts_o.x      = x;
  assign sts_o.n      = n;
  assign sts_o.nn     = nn;
  assign sts_o.row_ok = ysum < (ROW_W+1)'(SCREEN_H);

  assign program_counter_o = pc_q;
  assign index_value_o     = i_q;
  assign flag_value_o      = rf_q[REG_VF];
  assign read_data_o       = rdata_q;
  assign pixel_on_o        = pon_q;
  assign key_wait_o        = kw_q;
  assign sound_level_o     = sound_q;
  assign delay_level_o     = delay_q;

endmodule

FILE: sv/c8x_ctrl.sv
// ----------------------------------------------------------------------------
// c8x_ctrl: executor sequencer
// Decodes the latched word and steps the datapath through micro-ops.
// ----------------------------------------------------------------------------
module c8x_ctrl import c8x_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic start,
  output logic busy,
  output logic done_o,
  input  sts_t sts_i,
  output cmd_t cmd_o
);

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_ITEM = 4'd1;
  localparam logic [3:0] S_RDVY = 4'd2;
  localparam logic [3:0] S_EXEC = 4'd3;
  localparam logic [3:0] S_ALUR = 4'd4;
  localparam logic [3:0] S_DROW = 4'd5;
  localparam logic [3:0] S_DRFB = 4'd6;
  localparam logic [3:0] S_DRWR = 4'd7;
  localparam logic [3:0] S_BCD  = 4'd8;
  localparam logic [3:0] S_ST   = 4'd9;
  localparam logic [3:0] S_LDRD = 4'd10;
  localparam logic [3:0] S_LDWR = 4'd11;
  localparam logic [3:0] S_RDAT = 4'd12;
  localparam logic [3:0] S_PIX  = 4'd13;
  localparam logic [3:0] S_DONE = 4'd14;

  logic [3:0]       state_q, state_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic             flag_op, plain_op;

  assign flag_op  = (sts_i.n == ALU_ADD) || (sts_i.n == ALU_SUB) || (sts_i.n == ALU_SHR) ||
                    (sts_i.n == ALU_SUBN) || (sts_i.n == ALU_SHL);
  assign plain_op = (sts_i.n == ALU_MOV) || (sts_i.n == ALU_OR) ||
                    (sts_i.n == ALU_AND) || (sts_i.n == ALU_XOR);

  always_comb begin
    state_d   = state_q;
    cnt_d     = cnt_q;
    cmd_o.uop = UOP_NONE;
    cmd_o.cnt = cnt_q;
    case (state_q)
      S_IDLE: begin
        if (start) begin
          cmd_o.uop = UOP_LATCH;
          state_d   = S_ITEM;
        end
      end
      S_ITEM: begin
        cnt_d = '0;
        case (sts_i.kind)
          KIND_EXEC: begin
            cmd_o.uop = UOP_LDVX; state_d = S_RDVY;
          end
          KIND_MEMWR: begin
            cmd_o.uop = UOP_MEMWR; state_d = S_DONE;
          end
          KIND_MEMRD: begin
            cmd_o.uop = UOP_MEMRD; state_d = S_RDAT;
          end
          default: begin
            cmd_o.uop = UOP_FBRD_PIX; state_d = S_PIX;
          end
        endcase
      end
      S_RDAT: begin
        cmd_o.uop = UOP_RDATA; state_d = S_DONE;
      end
      S_PIX: begin
        cmd_o.uop = UOP_PIXEL; state_d = S_DONE;
      end
      S_RDVY: begin
        cmd_o.uop = UOP_LDVY; state_d = S_EXEC;
      end
      S_EXEC: begin
        state_d = S_DONE;
        case (sts_i.op_hi)
          OPG_ALU: begin
            if (flag_op) begin
              cmd_o.uop = UOP_ALU_FLAG; state_d = S_ALUR;
            end else if (plain_op) begin
              cmd_o.uop = UOP_ALU_RES;
            end
          end
          OPG_DRW: begin
            cmd_o.uop = UOP_DR_INIT; state_d = S_DROW;
          end
          OPG_MISC: begin
            if (sts_i.nn == FN_BCD)        state_d = S_BCD;
            else if (sts_i.nn == FN_STORE) state_d = S_ST;
            else if (sts_i.nn == FN_LOAD)  state_d = S_LDRD;
            else                           cmd_o.uop = UOP_SIMPLE;
          end
          default: cmd_o.uop = UOP_SIMPLE;
        endcase
      end
      S_ALUR: begin
        cmd_o.uop = UOP_ALU_RES; state_d = S_DONE;
      end
      // one sprite row: fetch byte, read frame row, write XORed row
      S_DROW: begin
        if (cnt_q == sts_i.n || !sts_i.row_ok) begin
          state_d = S_DONE;
        end else begin
          cmd_o.uop = UOP_DR_MEM; state_d = S_DRFB;
        end
      end
      S_DRFB: begin
        cmd_o.uop = UOP_DR_FBRD; state_d = S_DRWR;
      end
      S_DRWR: begin
        cmd_o.uop = UOP_DR_WR;
        cnt_d     = cnt_q + 1'b1;
        state_d   = S_DROW;
      end
      S_BCD: begin
        cmd_o.uop = UOP_BCD;
        cnt_d     = cnt_q + 1'b1;
        if (cnt_q == CNT_W'(2)) state_d = S_DONE;
      end
      S_ST: begin
        cmd_o.uop = UOP_ST;
        cnt_d     = cnt_q + 1'b1;
        if (cnt_q == sts_i.x) state_d = S_DONE;
      end
      S_LDRD: begin
        cmd_o.uop = UOP_LD_RD; state_d = S_LDWR;
      end
      S_LDWR: begin
        cmd_o.uop = UOP_LD_WR;
        cnt_d     = cnt_q + 1'b1;
        state_d   = (cnt_q == sts_i.x) ? S_DONE : S_LDRD;
      end
      S_DONE: state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
    end
  end

  assign busy   = state_q != S_IDLE;
  assign done_o = state_q == S_DONE;

  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |=> busy) else $error("accepted word did not raise busy");
  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |=> !busy) else $error("busy after result strobe");
  a_draw_rows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_DRWR) |-> (cnt_q < sts_i.n)) else $error("sprite row past height");
  a_blk_cnt: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_ST || state_q == S_LDWR) |-> (cnt_q <= sts_i.x))
    else $error("block transfer past VX");
  a_bcd_cnt: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_BCD) |-> (cnt_q <= CNT_W'(2))) else $error("BCD digit count");

endmodule

FILE: sv/chip8_instruction_executor_unit.sv
// ----------------------------------------------------------------------------
// chip8_instruction_executor_unit: CHIP-8 opcode executor, top level
// Each item steps through micro-ops: memory writes store, reads then capture;
// opcodes load VX and VY, then execute or run ALU flag then result, BCD digits,
// V0..VX block moves or the sprite row loop (memory read, frame row read, row
// write). One item at a time; the next is taken the cycle after done_o.
// Reset clears registers, pc to 0x200, stack pointer and display (row valid
// bits); memory and stack contents stay undefined. done_o cannot be stalled.
// ----------------------------------------------------------------------------
module chip8_instruction_executor_unit import c8x_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start,
  output logic              busy,
  output logic              done_o,
  input  logic [1:0]        kind_i,
  input  logic [15:0]       opcode_i,
  input  logic [15:0]       key_states_i,
  input  logic [7:0]        random_byte_i,
  input  logic [ADDR_W-1:0] mem_address_i,
  input  logic [7:0]        mem_write_data_i,
  input  logic [PIX_W-1:0]  pixel_index_i,
  output logic [ADDR_W-1:0] program_counter_o,
  output logic [15:0]       index_value_o,
  output logic [7:0]        flag_value_o,
  output logic [7:0]        read_data_o,
  output logic              pixel_on_o,
  output logic              key_wait_o,
  output logic [7:0]        sound_level_o,
  output logic [7:0]        delay_level_o
);

  cmd_t cmd;
  sts_t sts;

  c8x_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start  (start),
    .busy   (busy),
    .done_o (done_o),
    .sts_i  (sts),
    .cmd_o  (cmd)
  );

  c8x_dpath u_dpath (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cmd_i             (cmd),
    .sts_o             (sts),
    .kind_i            (kind_i),
    .opcode_i          (opcode_i),
    .key_states_i      (key_states_i),
    .random_byte_i     (random_byte_i),
    .mem_address_i     (mem_address_i),
    .mem_write_data_i  (mem_write_data_i),
    .pixel_index_i     (pixel_index_i),
    .program_counter_o (program_counter_o),
    .index_value_o     (index_value_o),
    .flag_value_o      (flag_value_o),
    .read_data_o       (read_data_o),
    .pixel_on_o        (pixel_on_o),
    .key_wait_o        (key_wait_o),
    .sound_level_o     (sound_level_o),
    .delay_level_o     (delay_level_o)
  );

endmodule
